// File: rtl/sssp_pkg.sv
// Shared types and constants for the single-source shortest path block.
// No dependencies.
package sssp_pkg;
	localparam int VertexBits = 4;
	localparam int DistBits   = 20;
	localparam int CountBits  = 5;
	localparam int WeightIn   = 16;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_RUN   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [VertexBits-1:0] first_vertex;
		logic [VertexBits-1:0] second_vertex;
		logic [WeightIn-1:0]   edge_weight;
		logic [VertexBits-1:0] source_vertex;
	} cmd_t;

	typedef struct packed {
		logic [VertexBits-1:0] vertex;
		logic [DistBits-1:0]   distance;
		logic                  reachable;
		logic [VertexBits-1:0] parent;
		logic                  has_parent;
		logic                  load_error;
		logic                  last;
	} res_t;
endpackage

// File: rtl/sssp_if.sv
// Valid/ready channel interface carrying one payload type.
// No dependencies; the payload type is given as a parameter.
interface sssp_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/single_source_shortest_path.sv
// A run initializes the n vertex entries in use, then works in rounds until no reached
// vertex is left unsettled. Each round scans the vertex memory one entry per cycle and
// settles the nearest one, then reads each stored edge to update its unsettled neighbors.
// Throughput: one add or clear per cycle while idle; one run at a time, until its last result.
// Reset: edge count, error flag and vertex count cleared/set; memories not cleared.
// Depends on sssp_pkg and sssp_if.
module single_source_shortest_path #(
	parameter int MAX_VERTICES = 16,
	parameter int MAX_EDGES    = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	sssp_if.sink   cmd,
	sssp_if.sink   cfg,
	sssp_if.source res
);
	import sssp_pkg::*;

	localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EI = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EC = $clog2(MAX_EDGES + 1);
	localparam int NC = $clog2(MAX_VERTICES + 1);
	localparam logic [DistBits:0] DMAX = (DistBits+1)'((1 << DistBits) - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_SCAN, S_SCAN_LAST, S_PICK, S_EREAD, S_EVAL, S_VRD, S_VWR,
		S_OREAD, S_OUT
	} state_t;

	typedef struct packed {
		logic [DistBits-1:0] path_len;
		logic [VI-1:0]       pred;
		logic                settled;
		logic                reached;
	} vent_t;

	// memories
	logic [VertexBits-1:0]  ea_mem [MAX_EDGES];
	logic [VertexBits-1:0]  eb_mem [MAX_EDGES];
	logic [WEIGHT_BITS-1:0] ec_mem [MAX_EDGES];
	vent_t                  v_mem  [MAX_VERTICES];

	state_t state_q;
	logic [CountBits-1:0] vcount_q;
	logic [EC-1:0] etotal_q;
	logic dropped_q;
	logic [NC-1:0] n_q;
	logic [VI-1:0] src_q;
	logic src_ok_q;
	logic [NC-1:0] idx_q;
	logic [EC-1:0] eidx_q;
	logic found_q;
	logic [VI-1:0] u_q;
	logic [DistBits-1:0] ud_q, bestd_q;
	logic [VI-1:0] bestp_q;
	logic [VertexBits-1:0] ra_q, rb_q;
	logic [WEIGHT_BITS-1:0] rc_q;
	vent_t vrd_q;
	logic [VI-1:0] oth_q;
	logic [DistBits-1:0] nd_q;
	logic [NC-1:0] rd_idx_q;
	res_t res_q;
	logic res_v_q;

	logic [NC-1:0] n_now;
	always_comb begin
		if (vcount_q == '0) n_now = NC'(1);
		else if (32'(vcount_q) > MAX_VERTICES) n_now = NC'(MAX_VERTICES);
		else n_now = NC'(vcount_q);
	end

	logic cmd_fire, add_ok;
	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign add_ok = (32'(cmd.data.first_vertex) < 32'(n_now))
		&& (32'(cmd.data.second_vertex) < 32'(n_now))
		&& (32'(etotal_q) < MAX_EDGES);

	assign res.valid = res_v_q;
	assign res.data  = res_q;

	// edge memory write and read
	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.data.opcode == OP_ADD && add_ok) begin
			ea_mem[etotal_q[EI-1:0]] <= cmd.data.first_vertex;
			eb_mem[etotal_q[EI-1:0]] <= cmd.data.second_vertex;
			ec_mem[etotal_q[EI-1:0]] <= WEIGHT_BITS'(cmd.data.edge_weight);
		end
		ra_q <= ea_mem[eidx_q[EI-1:0]];
		rb_q <= eb_mem[eidx_q[EI-1:0]];
		rc_q <= ec_mem[eidx_q[EI-1:0]];
	end

	// vertex memory: one write port, one registered read
	logic v_we;
	logic [VI-1:0] v_wa, v_ra;
	vent_t v_wd;
	always_ff @(posedge clk) begin
		if (v_we) v_mem[v_wa] <= v_wd;
		vrd_q <= v_mem[v_ra];
	end

	logic [VertexBits-1:0] oth_c;
	logic hit_c;
	always_comb begin
		hit_c = 1'b0;
		oth_c = rb_q;
		if (32'(ra_q) == 32'(u_q)) begin
			hit_c = 1'b1;
			oth_c = rb_q;
		end else if (32'(rb_q) == 32'(u_q)) begin
			hit_c = 1'b1;
			oth_c = ra_q;
		end
	end

	logic [DistBits:0] sum_c;
	assign sum_c = (DistBits+1)'(ud_q) + (DistBits+1)'(rc_q);

	logic cand_c;
	assign cand_c = vrd_q.reached && !vrd_q.settled && (!found_q || vrd_q.path_len < bestd_q);

	always_comb begin
		v_we = 1'b0;
		v_wa = u_q;
		v_wd = '0;
		v_ra = idx_q[VI-1:0];
		unique case (state_q)
			S_INIT: begin
				v_we = 1'b1;
				v_wa = idx_q[VI-1:0];
				v_wd.reached = src_ok_q && (idx_q[VI-1:0] == src_q);
			end
			S_PICK: begin
				v_we = found_q;
				v_wa = u_q;
				v_wd.path_len = bestd_q;
				v_wd.pred = bestp_q;
				v_wd.settled = 1'b1;
				v_wd.reached = 1'b1;
			end
			S_EVAL: v_ra = oth_c[VI-1:0];
			S_VRD:  v_ra = oth_q;
			S_VWR: begin
				v_wa = oth_q;
				v_we = !vrd_q.settled && (!vrd_q.reached || nd_q < vrd_q.path_len);
				v_wd.path_len = nd_q;
				v_wd.pred = u_q;
				v_wd.settled = 1'b0;
				v_wd.reached = 1'b1;
			end
			S_OREAD: v_ra = rd_idx_q[VI-1:0];
			S_OUT:   v_ra = rd_idx_q[VI-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vcount_q  <= CountBits'(16);
			etotal_q  <= '0;
			dropped_q <= 1'b0;
			res_v_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) vcount_q <= cfg.data;
			if (res_v_q && res.ready && state_q != S_OUT) res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						unique case (opcode_t'(cmd.data.opcode))
							OP_ADD: begin
								if (add_ok) etotal_q <= etotal_q + EC'(1);
								else dropped_q <= 1'b1;
							end
							OP_CLEAR: begin
								etotal_q  <= '0;
								dropped_q <= 1'b0;
							end
							OP_RUN: begin
								n_q      <= n_now;
								src_q    <= cmd.data.source_vertex[VI-1:0];
								src_ok_q <= 32'(cmd.data.source_vertex) < 32'(n_now);
								idx_q    <= '0;
								state_q  <= S_INIT;
							end
							OP_NONE: ;
						endcase
					end
				end
				S_INIT: begin
					if (idx_q == n_q - NC'(1)) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= src_ok_q ? S_SCAN : S_OREAD;
						rd_idx_q <= '0;
					end else idx_q <= idx_q + NC'(1);
				end
				S_SCAN: begin
					// read of idx issued; data arrives next cycle
					idx_q <= idx_q + NC'(1);
					state_q <= S_SCAN_LAST;
				end
				S_SCAN_LAST: begin
					if (cand_c) begin
						found_q <= 1'b1;
						bestd_q <= vrd_q.path_len;
						bestp_q <= vrd_q.pred;
						u_q     <= VI'(idx_q - NC'(1));
					end
					if (idx_q == n_q) state_q <= S_PICK;
					else idx_q <= idx_q + NC'(1);
				end
				S_PICK: begin
					if (!found_q) begin
						rd_idx_q <= '0;
						state_q  <= S_OREAD;
					end else begin
						ud_q    <= bestd_q;
						eidx_q  <= '0;
						state_q <= (etotal_q == '0) ? S_SCAN : S_EREAD;
						idx_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_EREAD: state_q <= S_EVAL;
				S_EVAL: begin
					oth_q <= oth_c[VI-1:0];
					nd_q  <= (sum_c > DMAX) ? DMAX[DistBits-1:0] : sum_c[DistBits-1:0];
					if (hit_c && 32'(oth_c) < 32'(n_q)) state_q <= S_VWR;
					else if (eidx_q + EC'(1) == etotal_q) begin
						idx_q <= '0; found_q <= 1'b0; state_q <= S_SCAN;
					end else begin
						eidx_q <= eidx_q + EC'(1); state_q <= S_EREAD;
					end
				end
				S_VWR: begin
					if (eidx_q + EC'(1) == etotal_q) begin
						idx_q <= '0; found_q <= 1'b0; state_q <= S_SCAN;
					end else begin
						eidx_q <= eidx_q + EC'(1); state_q <= S_EREAD;
					end
				end
				S_VRD: state_q <= S_VWR;
				S_OREAD: state_q <= S_OUT;
				S_OUT: begin
					if (!res_v_q || res.ready) begin
						res_v_q <= 1'b1;
						res_q.vertex     <= VertexBits'(rd_idx_q);
						res_q.reachable  <= vrd_q.reached;
						res_q.distance   <= vrd_q.reached ? vrd_q.path_len : '0;
						res_q.has_parent <= vrd_q.reached && (rd_idx_q[VI-1:0] != src_q);
						res_q.parent     <= (vrd_q.reached && (rd_idx_q[VI-1:0] != src_q))
							? VertexBits'(vrd_q.pred) : '0;
						res_q.load_error <= dropped_q;
						res_q.last       <= (rd_idx_q == n_q - NC'(1));
						if (rd_idx_q == n_q - NC'(1)) state_q <= S_IDLE;
						else begin
							rd_idx_q <= rd_idx_q + NC'(1);
							state_q  <= S_OREAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: tb/sv/sssp_checker.sv
`timescale 1ns / 1ps
// Checker for the shortest path block: watches command, config and result channels,
// predicts the per-vertex results of each run and compares them. Depends on sssp_pkg.
module sssp_checker
	import sssp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_ready,
	input  cmd_t cmd_data,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CountBits-1:0] cfg_data,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res_data,
	output int   fail_count,
	output int   pending_count
);
	localparam int NV = 16;
	localparam int NE = 64;
	localparam logic [DistBits-1:0] DMAX = '1;

	logic [CountBits-1:0]  vcount;
	logic [VertexBits-1:0] end_a [NE];
	logic [VertexBits-1:0] end_b [NE];
	logic [WeightIn-1:0]   cost [NE];
	int                    stored;
	logic                  dropped;
	res_t                  expected_q [$];

	assign pending_count = expected_q.size();

	function automatic int vertices_in_use();
		if (vcount == 0) return 1;
		if (vcount > NV) return NV;
		return vcount;
	endfunction

	task automatic predict_paths(input int src);
		int n, u, o;
		logic [DistBits:0] nd;
		logic [DistBits-1:0] best [NV];
		int par [NV];
		bit done [NV], seen [NV], found;
		res_t r;
		n = vertices_in_use();
		for (int i = 0; i < NV; i++) begin
			best[i] = 0; par[i] = 0; done[i] = 0; seen[i] = 0;
		end
		if (src < n) begin
			seen[src] = 1;
			for (int k = 0; k < n; k++) begin
				found = 0; u = 0;
				for (int i = 0; i < n; i++)
					if (seen[i] && !done[i] && (!found || best[i] < best[u])) begin
						u = i; found = 1;
					end
				if (!found) break;
				done[u] = 1;
				for (int e = 0; e < stored; e++) begin
					if (end_a[e] == u) o = end_b[e];
					else if (end_b[e] == u) o = end_a[e];
					else continue;
					if (o >= n || done[o]) continue;
					nd = best[u] + cost[e];
					if (nd > DMAX) nd = DMAX;
					if (!seen[o] || nd[DistBits-1:0] < best[o]) begin
						best[o] = nd[DistBits-1:0]; par[o] = u; seen[o] = 1;
					end
				end
			end
		end
		for (int v = 0; v < n; v++) begin
			r.vertex     = VertexBits'(v);
			r.distance   = seen[v] ? best[v] : '0;
			r.reachable  = seen[v];
			r.has_parent = seen[v] && v != src;
			r.parent     = r.has_parent ? VertexBits'(par[v]) : '0;
			r.load_error = dropped;
			r.last       = (v + 1 == n);
			expected_q.insert(expected_q.size(), r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t x;
		int n;
		if (!arst_n) begin
			vcount = CountBits'(16); stored = 0; dropped = 0; fail_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) vcount = cfg_data;
			if (cmd_valid && cmd_ready) begin
				n = vertices_in_use();
				case (opcode_t'(cmd_data.opcode))
					OP_ADD: begin
						if (cmd_data.first_vertex >= n || cmd_data.second_vertex >= n
								|| stored >= NE) begin
							dropped = 1;
						end else begin
							end_a[stored] = cmd_data.first_vertex;
							end_b[stored] = cmd_data.second_vertex;
							cost[stored]  = cmd_data.edge_weight;
							stored++;
						end
					end
					OP_RUN: predict_paths(cmd_data.source_vertex);
					OP_CLEAR: begin
						stored = 0; dropped = 0;
					end
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result transaction: %p", res_data);
					fail_count++;
				end else begin
					x = expected_q.pop_front();
					if (res_data.vertex !== x.vertex) begin
						$error("vertex: expected %0d actual %0d", x.vertex, res_data.vertex);
						fail_count++;
					end
					if (res_data.distance !== x.distance) begin
						$error("distance: expected %0d actual %0d", x.distance, res_data.distance);
						fail_count++;
					end
					if (res_data.reachable !== x.reachable) begin
						$error("reachable: expected %0d actual %0d", x.reachable,
							res_data.reachable);
						fail_count++;
					end
					if (res_data.parent !== x.parent) begin
						$error("parent: expected %0d actual %0d", x.parent, res_data.parent);
						fail_count++;
					end
					if (res_data.has_parent !== x.has_parent) begin
						$error("has_parent: expected %0d actual %0d", x.has_parent,
							res_data.has_parent);
						fail_count++;
					end
					if (res_data.load_error !== x.load_error) begin
						$error("load_error: expected %0d actual %0d", x.load_error,
							res_data.load_error);
						fail_count++;
					end
					if (res_data.last !== x.last) begin
						$error("last: expected %0d actual %0d", x.last, res_data.last);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the shortest path testbench: clock, reset, edge/run/clear stimulus,
// vertex-count phases and verdict. Depends on sssp_pkg, sssp_if, sssp_checker and the DUT.
module testbench;
	import sssp_pkg::*;

	localparam longint CycleLimit = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	longint cycles = 0;
	int fail_count, pending_count;
	bit res_steady = 0;

	sssp_if #(.payload_t(cmd_t)) cmd (.clk(clk));
	sssp_if #(.payload_t(logic [CountBits-1:0])) cfg (.clk(clk));
	sssp_if #(.payload_t(res_t)) res (.clk(clk));

	single_source_shortest_path dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg),
		.res(res));

	sssp_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd.valid), .cmd_ready(cmd.ready), .cmd_data(cmd.data),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_data(cfg.data),
		.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always #5 clk = ~clk;

	initial begin
		cmd.valid = 0; cmd.data = '0;
		cfg.valid = 0; cfg.data = '0;
		res.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk)
		res.ready <= res_steady || ($urandom_range(99) >= 25);

	task automatic send(input cmd_t c, input bit steady);
		if (!steady)
			while ($urandom_range(99) < 25) begin
				cmd.valid <= 0;
				@(posedge clk);
			end
		cmd.valid <= 1;
		cmd.data  <= c;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	task automatic add_edge(input int a, input int b, input int w, input bit steady = 0);
		cmd_t c;
		c = '0;
		c.opcode = OP_ADD; c.first_vertex = VertexBits'(a); c.second_vertex = VertexBits'(b);
		c.edge_weight = WeightIn'(w); c.source_vertex = VertexBits'($urandom);
		send(c, steady);
	endtask

	task automatic simple(input opcode_t op, input int s, input bit steady = 0);
		cmd_t c;
		c = $bits(cmd_t)'($urandom);
		c.opcode = op; c.source_vertex = VertexBits'(s);
		send(c, steady);
	endtask

	task automatic set_count(input int n);
		cmd.valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		cfg.valid <= 1;
		cfg.data  <= CountBits'(n);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
	endtask

	initial begin
		int n, k;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		add_edge(0, 15, 16'hFFFF);
		add_edge(15, 14, 16'hFFFF);
		add_edge(3, 3, 5);
		add_edge(1, 2, 0);
		add_edge(0, 1, 7);
		add_edge(0, 2, 3);
		simple(OP_RUN, 0);
		simple(OP_RUN, 15);
		simple(OP_NONE, 4);
		set_count(0);
		simple(OP_RUN, 0);
		add_edge(1, 0, 1);
		simple(OP_RUN, 1);
		set_count(31);
		for (int i = 0; i < 18; i++) add_edge(i % 16, (i + 1) % 16, 16'hFFFF, 1);
		simple(OP_RUN, 5);
		set_count(4);
		simple(OP_RUN, 2);
		simple(OP_RUN, 9);
		simple(OP_CLEAR, 0);
		simple(OP_RUN, 0);
		for (int i = 0; i < 66; i++) add_edge(i % 4, (i + 3) % 4, $urandom, 1);
		simple(OP_RUN, 3);

		// random phases
		for (int ph = 0; ph < 6; ph++) begin
			n = (ph == 0) ? 16 : (ph == 1) ? 1 : $urandom_range(2, 16);
			set_count(n);
			simple(OP_CLEAR, 0);
			for (int j = 0; j < 9; j++) begin
				k = $urandom_range(99);
				if (k < 70)
					add_edge($urandom_range(n - 1), $urandom_range(n - 1),
						($urandom_range(3) == 0) ? $urandom : $urandom_range(40),
						j < 4);
				else if (k < 75) add_edge($urandom, $urandom, $urandom);
				else if (k < 90) simple(OP_RUN, ($urandom_range(7) == 0) ? $urandom :
					$urandom_range(n - 1));
				else if (k < 95) simple(OP_CLEAR, 0);
				else simple(OP_NONE, $urandom);
			end
			simple(OP_RUN, $urandom_range(n - 1));
		end

		cmd.valid <= 0;
		res_steady = 1;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
